>>> rtl/i2cdw_pkg.sv
// Shared types and constants for the display write master.
`timescale 1ns / 1ps

package i2cdw_pkg;

    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_PHASE_TICKS    = 1'd1;

    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd120;
    localparam logic [7:0] PHASE_TICKS_RESET    = 8'd10;

    localparam logic [7:0] CTRL_DATA = 8'h40;
    localparam logic [7:0] CTRL_CMD  = 8'h00;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_CMD   = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] phase_ticks;
    } cfg_t;

    typedef struct packed {
        logic scl_out;
        logic sda_out;
        logic busy_res;
        logic done_res;
        logic nack_seen;
        logic rejected;
    } res_t;

endpackage

>>> rtl/i2cdw_channels.sv
// Handshake channel interfaces: tick input, result output, config write.
`timescale 1ns / 1ps

interface i2cdw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] payload;
    logic       sda_in;

    modport source (output valid, output mode, output payload, output sda_in, input ready);
    modport sink   (input valid, input mode, input payload, input sda_in, output ready);
endinterface

interface i2cdw_out_if;
    logic valid;
    logic ready;
    logic scl_out;
    logic sda_out;
    logic busy_res;
    logic done_res;
    logic nack_seen;
    logic rejected;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output nack_seen, output rejected, input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input nack_seen, input rejected, output ready);
endinterface

interface i2cdw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [i2cdw_pkg::CfgIdxW-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/i2cdw_engine.sv
// Bus phase sequencer: one tick word in, one pin/status result out.
`timescale 1ns / 1ps

module i2cdw_engine
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick,
    input  logic [1:0]      mode,
    input  logic [7:0]      payload,
    input  logic            sda_in,
    input  i2cdw_pkg::cfg_t cfg,
    output i2cdw_pkg::res_t res
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_START_C   = 4'd3,
        PH_BIT_SETUP = 4'd4,
        PH_BIT_HIGH  = 4'd5,
        PH_BIT_LOW   = 4'd6,
        PH_ACK_SETUP = 4'd7,
        PH_ACK_HIGH  = 4'd8,
        PH_ACK_LOW   = 4'd9,
        PH_STOP_A    = 4'd10
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] byte_slot;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic [7:0] held_payload;
        logic       is_data_write;
        logic [7:0] tick_count;
        logic       nack_accum;
        logic       scl_level;
        logic       sda_level;
    } state_t;

    state_t     st_reg;
    state_t     st_next;
    logic       request;
    logic       go;
    phase_t     go_phase;
    logic       done;
    logic       rej;
    logic [7:0] limit;
    logic [8:0] tick_inc;

    assign request  = (mode == i2cdw_pkg::MODE_CMD) || (mode == i2cdw_pkg::MODE_DATA);
    assign limit    = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
    assign tick_inc = {1'b0, st_reg.tick_count} + 9'd1;

    always_comb
    begin
        st_next  = st_reg;
        go       = 1'b0;
        go_phase = PH_IDLE;
        done     = 1'b0;
        rej      = 1'b0;

        if (st_reg.phase == PH_IDLE || st_reg.phase > PH_STOP_A)
        begin
            st_next.phase = PH_IDLE;
            if (request)
            begin
                st_next.held_payload  = payload;
                st_next.is_data_write = (mode == i2cdw_pkg::MODE_DATA);
                st_next.nack_accum    = 1'b0;
                st_next.byte_slot     = 2'd0;
                st_next.bit_count     = 4'd0;
                go       = 1'b1;
                go_phase = PH_START_A;
            end
        end
        else
        begin
            rej = request;
            if (tick_inc >= {1'b0, limit})
            begin
                case (st_reg.phase)
                    PH_START_A:
                    begin
                        go       = 1'b1;
                        go_phase = PH_START_B;
                    end
                    PH_START_B:
                    begin
                        go       = 1'b1;
                        go_phase = PH_START_C;
                    end
                    PH_START_C:
                    begin
                        st_next.byte_slot  = 2'd0;
                        st_next.bit_count  = 4'd0;
                        st_next.shift_byte = cfg.device_address;
                        go       = 1'b1;
                        go_phase = PH_BIT_SETUP;
                    end
                    PH_BIT_SETUP:
                    begin
                        go       = 1'b1;
                        go_phase = PH_BIT_HIGH;
                    end
                    PH_BIT_HIGH:
                    begin
                        go       = 1'b1;
                        go_phase = PH_BIT_LOW;
                    end
                    PH_BIT_LOW:
                    begin
                        st_next.shift_byte = {st_reg.shift_byte[6:0], 1'b0};
                        st_next.bit_count  = st_reg.bit_count + 4'd1;
                        go       = 1'b1;
                        go_phase = (st_next.bit_count >= 4'd8) ? PH_ACK_SETUP : PH_BIT_SETUP;
                    end
                    PH_ACK_SETUP:
                    begin
                        go       = 1'b1;
                        go_phase = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH:
                    begin
                        st_next.nack_accum = st_reg.nack_accum | sda_in;
                        go       = 1'b1;
                        go_phase = PH_ACK_LOW;
                    end
                    PH_ACK_LOW:
                    begin
                        go = 1'b1;
                        if (st_reg.byte_slot >= 2'd2)
                        begin
                            go_phase = PH_STOP_A;
                        end
                        else
                        begin
                            // load the next byte of the frame
                            st_next.byte_slot = st_reg.byte_slot + 2'd1;
                            st_next.bit_count = 4'd0;
                            if (st_reg.byte_slot == 2'd0)
                            begin
                                st_next.shift_byte = st_reg.is_data_write ?
                                                     i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_CMD;
                            end
                            else
                            begin
                                st_next.shift_byte = st_reg.held_payload;
                            end
                            go_phase = PH_BIT_SETUP;
                        end
                    end
                    PH_STOP_A:
                    begin
                        st_next.sda_level  = 1'b1;
                        st_next.scl_level  = 1'b1;
                        st_next.phase      = PH_IDLE;
                        st_next.tick_count = 8'd0;
                        done = 1'b1;
                    end
                    default:
                    begin
                        st_next.phase      = PH_IDLE;
                        st_next.tick_count = 8'd0;
                    end
                endcase
            end
            else
            begin
                st_next.tick_count = tick_inc[7:0];
            end
        end

        // apply pin levels of the phase being entered
        if (go)
        begin
            st_next.phase      = go_phase;
            st_next.tick_count = 8'd0;
            case (go_phase)
                PH_START_A:
                begin
                    st_next.sda_level = 1'b1;
                    st_next.scl_level = 1'b1;
                end
                PH_START_B:   st_next.sda_level = 1'b0;
                PH_START_C:   st_next.scl_level = 1'b0;
                PH_BIT_SETUP: st_next.sda_level = st_next.shift_byte[7];
                PH_BIT_HIGH:  st_next.scl_level = 1'b1;
                PH_BIT_LOW:
                begin
                    st_next.scl_level = 1'b0;
                    if (st_next.bit_count == 4'd7)
                    begin
                        st_next.sda_level = 1'b1;
                    end
                end
                PH_ACK_SETUP: st_next.sda_level = 1'b1;
                PH_ACK_HIGH:  st_next.scl_level = 1'b1;
                PH_ACK_LOW:   st_next.scl_level = 1'b0;
                PH_STOP_A:
                begin
                    st_next.sda_level = 1'b0;
                    st_next.scl_level = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.scl_out   = st_next.scl_level;
        res.sda_out   = st_next.sda_level;
        res.busy_res  = (st_next.phase != PH_IDLE);
        res.done_res  = done;
        res.nack_seen = done & st_next.nack_accum;
        res.rejected  = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase         <= PH_IDLE;
            st_reg.byte_slot     <= 2'd0;
            st_reg.bit_count     <= 4'd0;
            st_reg.shift_byte    <= 8'd0;
            st_reg.held_payload  <= 8'd0;
            st_reg.is_data_write <= 1'b0;
            st_reg.tick_count    <= 8'd0;
            st_reg.nack_accum    <= 1'b0;
            st_reg.scl_level     <= 1'b1;
            st_reg.sda_level     <= 1'b1;
        end
        else if (tick)
        begin
            st_reg <= st_next;
        end
    end

endmodule

>>> rtl/i2cdw_out_buf.sv
// Two-entry result register with skid slot.
`timescale 1ns / 1ps

module i2cdw_out_buf
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2cdw_pkg::res_t push_data,
    output logic            space,
    output logic            head_valid,
    output i2cdw_pkg::res_t head_data,
    input  logic            pop_ready
);

    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    i2cdw_pkg::res_t head_reg;
    i2cdw_pkg::res_t head_next;
    i2cdw_pkg::res_t skid_reg;
    i2cdw_pkg::res_t skid_next;
    logic            pop;

    assign space      = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = head_reg;
    assign pop        = head_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_next = push_data;
                end
                else
                begin
                    skid_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = skid_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = skid_reg;
                    skid_next = push_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

>>> rtl/i2c_display_write_master_unit.sv
// Top level of the tick-driven I2C display write master.
`timescale 1ns / 1ps

// Usage:
//   item   : one word per timer tick; mode 0 just advances time, mode 1 starts a
//            command write, mode 2 a data write (payload latched then). sda_in
//            is the sampled SDA level, read on the last tick of each ack high phase.
//   result : one word per accepted tick with the SCL/SDA drive levels after that
//            tick, busy, done (stop finished), nack_seen (with done) and
//            rejected (write request while busy).
//   cfg    : register writes, index 0 device address byte, index 1 ticks per
//            bus phase (0 acts as 1). Always ready; write only while idle.
// Timing: the result of a tick is written into the result register when the tick
//   word is accepted. Throughput: one tick per cycle while item ready is high; the
//   phase sequencer updates its state in the accepting cycle.
// Stall: a two-entry result register keeps item ready while one result waits;
//   item ready drops only when both entries are full.
// Reset: bus idle, both lines released, registers at address 120 and 10 ticks.

module i2c_display_write_master_unit
(
    input logic                clk,
    input logic                rst_n,
    i2cdw_in_if.sink           item,
    i2cdw_out_if.source        result,
    i2cdw_cfg_if.sink          cfg
);

    i2cdw_pkg::cfg_t cfg_reg;
    i2cdw_pkg::res_t eng_res;
    i2cdw_pkg::res_t head_res;
    logic            space;
    logic            tick;

    assign cfg.ready  = 1'b1;
    assign item.ready = space;
    assign tick       = item.valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= i2cdw_pkg::DEVICE_ADDRESS_RESET;
            cfg_reg.phase_ticks    <= i2cdw_pkg::PHASE_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                i2cdw_pkg::CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg.data;
                i2cdw_pkg::CFG_PHASE_TICKS:    cfg_reg.phase_ticks    <= cfg.data;
                default: ;
            endcase
        end
    end

    i2cdw_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .mode    (item.mode),
        .payload (item.payload),
        .sda_in  (item.sda_in),
        .cfg     (cfg_reg),
        .res     (eng_res)
    );

    i2cdw_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (tick),
        .push_data  (eng_res),
        .space      (space),
        .head_valid (result.valid),
        .head_data  (head_res),
        .pop_ready  (result.ready)
    );

    assign result.scl_out   = head_res.scl_out;
    assign result.sda_out   = head_res.sda_out;
    assign result.busy_res  = head_res.busy_res;
    assign result.done_res  = head_res.done_res;
    assign result.nack_seen = head_res.nack_seen;
    assign result.rejected  = head_res.rejected;

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick && eng_res.done_res |-> !eng_res.busy_res && eng_res.scl_out && eng_res.sda_out)
        else $error("stop completed with bus still busy or lines held");

    a_nack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        tick && eng_res.nack_seen |-> eng_res.done_res)
        else $error("nack reported without done");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick && eng_res.rejected |-> eng_res.busy_res || eng_res.done_res)
        else $error("request rejected while idle");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !space |-> result.valid)
        else $error("input stalled with no result pending");

endmodule
